/* rtl/mtfnc_pkg.sv */
// Shared types and constants of the move-to-front nibble compressor.
// Used by mtfnc_table and mtf_nibble_compressor_top; depends on nothing.
package mtfnc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CODE_W = 4;
    localparam int unsigned MAX_ENTRIES = 15;

    localparam logic [CODE_W-1:0] ESC_CODE = 4'hF;

    localparam logic [BYTE_W-1:0] DEFAULT_TABLE [MAX_ENTRIES] = '{
        8'h20, 8'h65, 8'h74, 8'h6F, 8'h61, 8'h73, 8'h72, 8'h69,
        8'h6E, 8'h63, 8'h6C, 8'h6D, 8'h68, 8'h64, 8'h75
    };

    typedef struct packed {
        logic              hit;
        logic [CODE_W-1:0] idx;
    } t_lookup;

endpackage

/* rtl/mtf_nibble_compressor_top.sv */
// Top level of the move-to-front nibble compressor.
// Depends on mtfnc_pkg and mtfnc_table.
//
// One byte is accepted per cycle unless a registered byte still waits for room
// in the result queue, which holds o_in_ready low. A byte is registered when it
// is accepted, looked up in the table and coded from that register, and its
// packed bytes are written into a two-entry result queue once the queue is
// empty or its last word is being taken. A byte yields no, one or two results;
// the output port moves one word per cycle through the queue while i_out_ready
// is high. Leftover nibbles are never flushed. The table is reset to its default
// string by the synchronous reset, and no byte is taken while reset is held.
module mtf_nibble_compressor_top #(
    parameter int unsigned TABLE_ENTRIES = 15
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_pend_valid;
    logic [3:0] r_pend_nibble;
    logic [7:0] r_q_byte [2];
    logic       r_q_last [2];
    logic [1:0] r_q_cnt;

    logic       n_pend_valid;
    logic [3:0] n_pend_nibble;
    logic [7:0] res_byte [2];
    logic [1:0] res_cnt;

    mtfnc_pkg::t_lookup lookup;
    logic       pop;
    logic       fire;

    mtfnc_table #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (r_in_byte),
        .i_update (fire),
        .o_lookup (lookup)
    );

    assign o_out_valid   = (r_q_cnt != 2'd0);
    assign o_out_byte    = r_q_byte[0];
    assign o_last_of_run = r_q_last[0];
    assign pop           = o_out_valid & i_out_ready;
    assign fire          = r_in_valid & ((r_q_cnt == 2'd0) | ((r_q_cnt == 2'd1) & pop));
    assign o_in_ready    = i_rst_n & (~r_in_valid | fire);

    always_comb begin
        res_byte[0]   = '0;
        res_byte[1]   = '0;
        res_cnt       = 2'd0;
        n_pend_valid  = 1'b0;
        n_pend_nibble = '0;
        if (lookup.hit) begin
            if (r_pend_valid) begin
                res_byte[0] = {lookup.idx, r_pend_nibble};
                res_cnt     = 2'd1;
            end else begin
                n_pend_valid  = 1'b1;
                n_pend_nibble = lookup.idx;
            end
        end else begin
            if (r_pend_valid) begin
                res_byte[0] = {mtfnc_pkg::ESC_CODE, r_pend_nibble};
                res_byte[1] = r_in_byte;
                res_cnt     = 2'd2;
            end else begin
                res_byte[0]   = {r_in_byte[3:0], mtfnc_pkg::ESC_CODE};
                res_cnt       = 2'd1;
                n_pend_valid  = 1'b1;
                n_pend_nibble = r_in_byte[7:4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_pend_valid  <= 1'b0;
            r_pend_nibble <= '0;
            r_q_cnt       <= 2'd0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_pend_valid  <= n_pend_valid;
                r_pend_nibble <= n_pend_nibble;
                r_q_cnt       <= res_cnt;
            end else if (pop) begin
                r_q_cnt <= r_q_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
        if (fire) begin
            r_q_byte[0] <= res_byte[0];
            r_q_byte[1] <= res_byte[1];
            r_q_last[0] <= (res_cnt == 2'd1);
            r_q_last[1] <= 1'b1;
        end else if (pop) begin
            r_q_byte[0] <= r_q_byte[1];
            r_q_last[0] <= r_q_last[1];
        end
    end

endmodule

/* rtl/mtfnc_table.sv */
// Move-to-front table: parallel search of one byte and the move-to-front update.
// Depends on mtfnc_pkg.
module mtfnc_table #(
    parameter int unsigned ENTRIES = 15
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [mtfnc_pkg::BYTE_W-1:0]        i_byte,
    input  logic                                i_update,
    output mtfnc_pkg::t_lookup                  o_lookup
);

    logic [mtfnc_pkg::BYTE_W-1:0] r_table [ENTRIES];
    logic [mtfnc_pkg::BYTE_W-1:0] n_table [ENTRIES];
    logic [ENTRIES-1:0]           match;
    logic [ENTRIES-1:1]           shift;
    logic                         found;

    always_comb begin
        o_lookup = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            match[i] = (r_table[i] == i_byte);
            if (match[i]) begin
                o_lookup.hit = 1'b1;
                o_lookup.idx = mtfnc_pkg::CODE_W'(i);
            end
        end
    end

    always_comb begin
        found = 1'b0;
        for (int i = ENTRIES - 1; i >= 1; i--) begin
            found    = found | match[i];
            shift[i] = found | ~o_lookup.hit;
        end
        n_table[0] = i_byte;
        for (int i = 1; i < ENTRIES; i++) begin
            n_table[i] = shift[i] ? r_table[i-1] : r_table[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_table[i] <= mtfnc_pkg::DEFAULT_TABLE[i];
            end
        end else if (i_update) begin
            r_table <= n_table;
        end
    end

endmodule

/* rtl/mtfnc_checker.sv */
// Port-level checks for mtf_nibble_compressor_top, with the bind that attaches them.
// Depends on mtf_nibble_compressor_top.
module mtfnc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_last_of_run
);

    logic in_acc;
    assign in_acc = i_in_valid & o_in_ready;

    a_out_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("output valid dropped before accept");

    a_out_word_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(o_out_byte) && $stable(o_last_of_run)))
        else $error("stalled output word changed");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_of_run) |=> o_out_valid)
        else $error("second word of a run missing");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_acc, 2))
        else $error("output word without an input byte");

endmodule

bind mtf_nibble_compressor_top mtfnc_checker u_mtfnc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_byte    (o_out_byte),
    .o_last_of_run (o_last_of_run)
);

/* tb/tb_top.sv */
// Self-checking testbench for mtf_nibble_compressor_top: queue-fed byte driver,
// output word monitor and a move-to-front packing predictor. Needs only the RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int          ENTRIES     = 15;
    localparam logic [3:0]  ESCAPE      = 4'hF;
    localparam int          RAND_ITEMS  = 1750;
    localparam int          IDLE_LIMIT  = 5000;
    localparam int          DRAIN_WAIT  = 10;
    localparam string       INIT_STRING = " etoasrinclmhdu";
    localparam string       ALPHABET    = " etoasrinclmhdugwyfbpvk.";

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_packed_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] in_byte = 8'h00;
    logic       out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;

    logic [7:0]   pending_bytes[$];
    t_packed_word expected_words[$];
    logic [7:0]   mtf_tab [ENTRIES];
    logic [3:0]   nib_hold;
    logic         nib_live;
    int           mismatches = 0;
    int           idle_cycles = 0;
    bit           send_calm = 1'b0;
    bit           recv_calm = 1'b0;

    mtf_nibble_compressor_top #(
        .TABLE_ENTRIES(ENTRIES)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (in_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_out_byte   (o_out_byte),
        .o_last_of_run(o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    function automatic void mtf_clear();
        for (int i = 0; i < ENTRIES; i++) begin
            mtf_tab[i] = INIT_STRING[i];
        end
        nib_hold = 4'h0;
        nib_live = 1'b0;
    endfunction

    function automatic void mtf_encode(input logic [7:0] b);
        int          pos;
        int          nbits;
        logic [15:0] acc;
        pos = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (pos < 0 && mtf_tab[i] == b) pos = i;
        end
        if (pos >= 0) begin
            acc   = 16'(pos);
            nbits = 4;
        end else begin
            acc   = {4'h0, b, ESCAPE};
            nbits = 12;
        end
        if (nib_live) begin
            acc   = {acc[11:0], nib_hold};
            nbits = nbits + 4;
        end
        while (nbits >= 8) begin
            expected_words.push_back('{data: acc[7:0], last: (nbits < 16)});
            acc   = acc >> 8;
            nbits = nbits - 8;
        end
        nib_live = (nbits != 0);
        nib_hold = nib_live ? acc[3:0] : 4'h0;
        if (pos < 0) pos = ENTRIES - 1;
        for (int i = pos; i > 0; i--) begin
            mtf_tab[i] = mtf_tab[i-1];
        end
        mtf_tab[0] = b;
    endfunction

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0) send_calm <= ~send_calm;
        if ($urandom_range(0, 63) == 0) recv_calm <= ~recv_calm;
    end

    always @(posedge i_clk) begin : driver
        int gap_left;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else if (!in_valid || o_in_ready) begin
            if (in_valid) mtf_encode(in_byte);
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                in_byte  <= pending_bytes.pop_front();
                in_valid <= 1'b1;
                gap_left = pick_gap(send_calm);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        int           stall_left;
        t_packed_word want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word: expected none, actual byte %h last %b",
                             $time, o_out_byte, o_last_of_run);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    if (o_out_byte !== want.data) begin
                        $display("%0t: out_byte mismatch: expected %h, actual %h",
                                 $time, want.data, o_out_byte);
                        mismatches++;
                    end
                    if (o_last_of_run !== want.last) begin
                        $display("%0t: last_of_run mismatch: expected %b, actual %b",
                                 $time, want.last, o_last_of_run);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                stall_left = pick_gap(recv_calm);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] prev;
        int         r;
        mtf_clear();
        foreach (pending_bytes[i]) pending_bytes.delete(i);
        pending_bytes = {8'h20, 8'h75, 8'h00, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h65,
                         8'h65, 8'h75, 8'h0F, 8'hF0, 8'h64, 8'h01, 8'h80, 8'h7F,
                         8'h20, 8'h20, 8'h78, 8'h68, 8'hFE, 8'h6D, 8'h6D, 8'h6C};
        prev = 8'h20;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 55) prev = ALPHABET[$urandom_range(0, ALPHABET.len() - 1)];
            else if (r >= 70) prev = 8'($urandom_range(0, 255));
            pending_bytes.push_back(prev);
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending_bytes.size() > 0 || in_valid || expected_words.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
